// ===== sv/irtp_pkg.sv =====
// Package for the interrupt report transmit packetizer: sizes, codes, microcode.
`default_nettype none
package irtp_pkg;

  localparam int RING_DEPTH   = 256;
  localparam int PACKET_BYTES = 8;
  localparam int FLAG_COUNT   = 32;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int MASK_W  = 32;
  localparam int FIDX_W  = $clog2(FLAG_COUNT);
  localparam int CFG_W   = 5;
  localparam int RIDX_W  = 1;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] HEX_GAP   = 8'd7;
  localparam logic [3:0] HEX_NINE  = 4'd9;

  localparam logic [RIDX_W-1:0] REG_SCAN_LOW  = 1'b0;
  localparam logic [RIDX_W-1:0] REG_SCAN_HIGH = 1'b1;

  typedef enum logic [1:0] {
    OP_RAISE = 2'd0,
    OP_PUT   = 2'd1,
    OP_POLL  = 2'd2,
    OP_ARM   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PKT, S_READ, S_LAST, S_SCAN,
    S_PUT0, S_PUT1, S_PUT2, S_PUT3, S_OUT
  } step_t;

  typedef enum logic [2:0] {
    U_DISPATCH, U_PKT_SETUP, U_READ, U_COMMIT, U_SCAN, U_PUT, U_EMIT
  } uop_t;

  typedef enum logic [1:0] {
    PUT_BSLASH, PUT_HI, PUT_LO, PUT_NL
  } put_sel_t;

  typedef enum logic [2:0] {
    J_NEVER, J_NO_POLL, J_READ_MORE, J_NO_FLAG, J_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    uop_t     uop;
    put_sel_t put_sel;
    jcond_t   jcond;
    step_t    target;
    step_t    seq;
  } uword_t;

  // Control store: one word per step.
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '{U_DISPATCH, PUT_BSLASH, J_NO_POLL, S_IDLE, S_PKT};
    unique case (s)
      S_IDLE: w = '{U_DISPATCH,  PUT_BSLASH, J_NO_POLL,   S_IDLE, S_PKT};
      S_PKT:  w = '{U_PKT_SETUP, PUT_BSLASH, J_NEVER,     S_PKT,  S_READ};
      S_READ: w = '{U_READ,      PUT_BSLASH, J_READ_MORE, S_READ, S_LAST};
      S_LAST: w = '{U_COMMIT,    PUT_BSLASH, J_NEVER,     S_LAST, S_SCAN};
      S_SCAN: w = '{U_SCAN,      PUT_BSLASH, J_NO_FLAG,   S_OUT,  S_PUT0};
      S_PUT0: w = '{U_PUT,       PUT_BSLASH, J_NEVER,     S_PUT0, S_PUT1};
      S_PUT1: w = '{U_PUT,       PUT_HI,     J_NEVER,     S_PUT1, S_PUT2};
      S_PUT2: w = '{U_PUT,       PUT_LO,     J_NEVER,     S_PUT2, S_PUT3};
      S_PUT3: w = '{U_PUT,       PUT_NL,     J_NEVER,     S_PUT3, S_OUT};
      S_OUT:  w = '{U_EMIT,      PUT_BSLASH, J_OUT_BUSY,  S_OUT,  S_IDLE};
      default: w = '{U_DISPATCH, PUT_BSLASH, J_NO_POLL,   S_IDLE, S_PKT};
    endcase
    return w;
  endfunction

  // Uppercase hex character of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] c;
    c = CH_ZERO + 8'(v);
    if (v > HEX_NINE) begin
      c = c + HEX_GAP;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/irtp_if.sv =====
// Handshake channel interfaces for input items and result words.
`default_nettype none
interface irtp_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [irtp_pkg::MASK_W-1:0]  raise_mask;
  logic [7:0]                   byte_value;
  logic                         endpoint_ready;

  modport source (output valid, operation, raise_mask, byte_value, endpoint_ready,
                  input ready);
  modport sink (input valid, operation, raise_mask, byte_value, endpoint_ready,
                output ready);
endinterface

interface irtp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         packet_valid;
  logic [irtp_pkg::LEN_W-1:0]   packet_length;
  logic [irtp_pkg::DATA_W-1:0]  packet_data;
  logic                         overflow_seen;

  modport source (output valid, packet_valid, packet_length, packet_data, overflow_seen,
                  input ready);
  modport sink (input valid, packet_valid, packet_length, packet_data, overflow_seen,
                output ready);
endinterface
`default_nettype wire

// ===== sv/interrupt_report_tx_packetizer.sv =====
// Top level of the interrupt report transmit packetizer.
//
// Input words arrive on the item channel (valid/ready) and carry an
// operation: raise ORs a mask into the pending interrupt flags, put appends
// one byte to the transmit ring, arm requests an empty frame, and poll runs
// a packet pass followed by a report scan. Only a poll produces a result
// word on the result channel. A poll is run by a small microprogram:
// setup, a read step for each packet byte from the ring RAM (at least
// one), a commit, the scan, four ring writes when a flag is reported, and
// the result load. The next item is accepted once the result is in the
// output register, so a held result does not stall the item side until a
// second poll completes. The scan range registers are written through the
// plain write port and take effect at the next report scan.
// Reset clears the ring pointers, pending flags, the armed and overflow
// flags, and the result valid flag, and restores scan range 4 to 26; ring
// contents are left as they are, since only written entries are ever read.
`default_nettype none
module interrupt_report_tx_packetizer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  irtp_in_if.sink                            item,
  irtp_out_if.source                         result,
  input  wire logic                          write_enable,
  input  wire logic [irtp_pkg::RIDX_W-1:0]   reg_index,
  input  wire logic [irtp_pkg::CFG_W-1:0]    write_data
);

  localparam int AW = irtp_pkg::RING_AW;
  localparam int LW = irtp_pkg::LEN_W;
  localparam int FC = irtp_pkg::FLAG_COUNT;
  localparam int FW = irtp_pkg::FIDX_W;

  // Sequencer state and the current control word.
  irtp_pkg::step_t  step;
  irtp_pkg::step_t  step_next;
  irtp_pkg::uword_t uw;

  // Architectural state.
  logic [AW-1:0]                 write_index;
  logic [AW-1:0]                 read_index;
  logic [FC-1:0]                 pending_flags;
  logic                          empty_frame_armed;
  logic                          overflow_sticky;
  logic [irtp_pkg::CFG_W-1:0]    scan_low;
  logic [irtp_pkg::CFG_W-1:0]    scan_high;

  // Per-poll working registers.
  logic                          ep_ready;
  logic                          send;
  logic [LW-1:0]                 tlen;
  logic [LW-1:0]                 cnt;
  logic                          rd_pend;
  logic [LW-1:0]                 rd_k;
  logic [irtp_pkg::DATA_W-1:0]   data;
  logic [FW-1:0]                 report_idx;

  // Datapath signals.
  logic                          accept;
  logic                          poll_taken;
  logic [AW-1:0]                 wi_nxt;
  logic                          ring_full;
  logic                          do_put;
  logic [7:0]                    put_byte;
  logic                          ram_we;
  logic [AW-1:0]                 ram_raddr;
  logic [7:0]                    ram_rdata;
  logic [AW:0]                   avail;
  logic                          send_now;
  logic [LW-1:0]                 tlen_now;
  logic [AW:0]                   ri_sum;
  logic [AW-1:0]                 ri_new;
  logic [FC-1:0]                 cand;
  logic [FC-1:0]                 iso;
  logic                          flag_found;
  logic [FW-1:0]                 found_idx;
  logic [7:0]                    idx_byte;
  logic                          out_free;
  logic                          jump;

  assign uw         = irtp_pkg::ucode(step);
  assign item.ready = (uw.uop == irtp_pkg::U_DISPATCH);
  assign accept     = item.valid && item.ready;
  assign poll_taken = accept && (irtp_pkg::op_t'(item.operation) == irtp_pkg::OP_POLL);
  assign out_free   = !result.valid || result.ready;

  // Ring fullness: the ring keeps one slot open so full and empty differ.
  assign wi_nxt    = (write_index == AW'(irtp_pkg::RING_DEPTH - 1)) ? '0
                                                                     : write_index + 1'b1;
  assign ring_full = (wi_nxt == read_index);

  // Report bytes come from the latched flag index.
  assign idx_byte = 8'(report_idx);

  always_comb begin
    put_byte = item.byte_value;
    do_put   = 1'b0;
    if (uw.uop == irtp_pkg::U_DISPATCH) begin
      do_put = accept && (irtp_pkg::op_t'(item.operation) == irtp_pkg::OP_PUT);
    end else if (uw.uop == irtp_pkg::U_PUT) begin
      do_put = 1'b1;
      unique case (uw.put_sel)
        irtp_pkg::PUT_BSLASH: put_byte = irtp_pkg::CH_BSLASH;
        irtp_pkg::PUT_HI:     put_byte = irtp_pkg::hex_digit(idx_byte[7:4]);
        irtp_pkg::PUT_LO:     put_byte = irtp_pkg::hex_digit(idx_byte[3:0]);
        irtp_pkg::PUT_NL:     put_byte = irtp_pkg::CH_NL;
        default:              put_byte = irtp_pkg::CH_NL;
      endcase
    end
  end

  assign ram_we    = do_put && !ring_full;
  assign ram_raddr = read_index + AW'(cnt);

  irtp_ram #(
    .WIDTH (8),
    .DEPTH (irtp_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_index),
    .wdata (put_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Packet size: pending bytes up to the ring end, capped at a full packet.
  always_comb begin
    if (write_index >= read_index) begin
      avail = (AW+1)'(write_index) - (AW+1)'(read_index);
    end else begin
      avail = (AW+1)'(irtp_pkg::RING_DEPTH) - (AW+1)'(read_index);
    end
    send_now = ep_ready && ((write_index != read_index) || empty_frame_armed);
    if (!send_now) begin
      tlen_now = '0;
    end else if (avail > (AW+1)'(irtp_pkg::PACKET_BYTES)) begin
      tlen_now = LW'(irtp_pkg::PACKET_BYTES);
    end else begin
      tlen_now = LW'(avail);
    end
  end

  assign ri_sum = (AW+1)'(read_index) + (AW+1)'(tlen);
  assign ri_new = (ri_sum >= (AW+1)'(irtp_pkg::RING_DEPTH))
                ? AW'(ri_sum - (AW+1)'(irtp_pkg::RING_DEPTH)) : AW'(ri_sum);

  // Report scan: lowest pending flag inside the configured range.
  always_comb begin
    for (int i = 0; i < FC; i++) begin
      cand[i] = pending_flags[i] && (i >= int'(scan_low)) && (i <= int'(scan_high));
    end
    iso        = cand & (~cand + 1'b1);
    flag_found = |cand;
    found_idx  = '0;
    for (int i = 0; i < FC; i++) begin
      if (iso[i]) begin
        found_idx = found_idx | FW'(i);
      end
    end
  end

  // Next step: the control word's jump condition picks target or fall-through.
  always_comb begin
    unique case (uw.jcond)
      irtp_pkg::J_NEVER:     jump = 1'b0;
      irtp_pkg::J_NO_POLL:   jump = !poll_taken;
      irtp_pkg::J_READ_MORE: jump = ((cnt + 1'b1) < tlen);
      irtp_pkg::J_NO_FLAG:   jump = !flag_found;
      irtp_pkg::J_OUT_BUSY:  jump = !out_free;
      default:               jump = 1'b0;
    endcase
    step_next = jump ? uw.target : uw.seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= irtp_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_low  <= irtp_pkg::CFG_W'(4);
      scan_high <= irtp_pkg::CFG_W'(26);
    end else if (write_enable) begin
      if (reg_index == irtp_pkg::REG_SCAN_LOW) begin
        scan_low <= write_data;
      end
      if (reg_index == irtp_pkg::REG_SCAN_HIGH) begin
        scan_high <= write_data;
      end
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index       <= '0;
      read_index        <= '0;
      pending_flags     <= '0;
      empty_frame_armed <= 1'b0;
      overflow_sticky   <= 1'b0;
      rd_pend           <= 1'b0;
      result.valid      <= 1'b0;
    end else begin
      if (ram_we) begin
        write_index <= wi_nxt;
      end
      if (do_put && ring_full) begin
        overflow_sticky <= 1'b1;
      end
      rd_pend <= 1'b0;
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (uw.uop)
        irtp_pkg::U_DISPATCH: begin
          if (accept && irtp_pkg::op_t'(item.operation) == irtp_pkg::OP_RAISE) begin
            pending_flags <= pending_flags | FC'(item.raise_mask);
          end
          if (accept && irtp_pkg::op_t'(item.operation) == irtp_pkg::OP_ARM) begin
            empty_frame_armed <= 1'b1;
          end
        end
        irtp_pkg::U_READ: begin
          rd_pend <= (cnt < tlen);
        end
        irtp_pkg::U_COMMIT: begin
          read_index <= ri_new;
          if (send) begin
            empty_frame_armed <= (tlen == LW'(irtp_pkg::PACKET_BYTES))
                              && (write_index == ri_new);
          end
        end
        irtp_pkg::U_SCAN: begin
          if (flag_found) begin
            pending_flags <= pending_flags & ~iso;
          end
        end
        irtp_pkg::U_EMIT: begin
          if (out_free) begin
            result.valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      data[rd_k*8 +: 8] <= ram_rdata;
    end
    unique case (uw.uop)
      irtp_pkg::U_DISPATCH: begin
        ep_ready <= item.endpoint_ready;
      end
      irtp_pkg::U_PKT_SETUP: begin
        send <= send_now;
        tlen <= tlen_now;
        cnt  <= '0;
        data <= '0;
      end
      irtp_pkg::U_READ: begin
        rd_k <= cnt;
        cnt  <= cnt + 1'b1;
      end
      irtp_pkg::U_SCAN: begin
        report_idx <= found_idx;
      end
      irtp_pkg::U_EMIT: begin
        if (out_free) begin
          result.packet_valid  <= send;
          result.packet_length <= tlen;
          result.packet_data   <= data;
          result.overflow_seen <= overflow_sticky;
        end
      end
      default: begin
      end
    endcase
  end

  // A ring write never makes the write pointer catch up with the read pointer.
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (wi_nxt != read_index))
    else $error("ring write would overfill the ring");

  // Read data is only captured inside the packet read steps.
  a_capture_window: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (step == irtp_pkg::S_READ || step == irtp_pkg::S_LAST))
    else $error("ring read data captured outside the packet read");

  // A new result word is only loaded by the result step.
  a_emit_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(step) == irtp_pkg::S_OUT))
    else $error("result loaded outside the result step");

  // The overflow flag is sticky until reset.
  a_overflow_sticky: assert property (@(posedge clk)
    !$past(rst) |-> !$fell(overflow_sticky))
    else $error("overflow flag cleared without reset");

  // The packet never exceeds the packet size.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (step == irtp_pkg::S_READ) |-> (tlen <= LW'(irtp_pkg::PACKET_BYTES)))
    else $error("packet length beyond packet size");

endmodule
`default_nettype wire

// ===== sv/irtp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module irtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== tb/irtp_packet_checker.sv =====
// Checker for the interrupt report packetizer: tracks ring, flags and scan range, compares packets.
`default_nettype none
module irtp_packet_checker
  import irtp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  irtp_in_if                     item_bus,
  irtp_out_if                    result_bus,
  input  wire logic              write_enable,
  input  wire logic [RIDX_W-1:0] reg_index,
  input  wire logic [CFG_W-1:0]  write_data,
  output int                     packets_due_count,
  output int                     mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_W-1:0] SCAN_LOW_AT_RESET  = 5'd4;
  localparam logic [CFG_W-1:0] SCAN_HIGH_AT_RESET = 5'd26;

  typedef struct packed {
    logic              sent;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] bytes;
    logic              ovf;
  } packet_t;

  logic [7:0]         ring_copy [RING_DEPTH];
  logic [RING_AW-1:0] wr_ptr;
  logic [RING_AW-1:0] rd_ptr;
  logic [MASK_W-1:0]  flags;
  logic               armed;
  logic               dropped;
  logic [CFG_W-1:0]   scan_lo;
  logic [CFG_W-1:0]   scan_hi;
  packet_t            packets_due [$];
  int                 fail_total = 0;

  initial begin
    packets_due_count = 0;
    mismatches = 0;
  end

  // One slot always stays free, so a full ring drops the byte and marks it.
  function automatic void ring_push(input logic [7:0] b);
    if (RING_AW'(wr_ptr + 1'b1) == rd_ptr) begin
      dropped = 1'b1;
    end else begin
      ring_copy[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
    end
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    logic [7:0] c;
    c = CH_ZERO + 8'(v);
    if (v > 4'd9) begin
      c = c + HEX_GAP;
    end
    return c;
  endfunction

  // Clears the lowest pending flag inside the scan range and queues its report line.
  function automatic void report_lowest_flag();
    int  i;
    logic found;
    found = 1'b0;
    if (scan_lo > scan_hi) begin
      return;
    end
    for (i = int'(scan_lo); i <= int'(scan_hi) && i < FLAG_COUNT && !found; i++) begin
      if (flags[i]) begin
        found = 1'b1;
        flags[i] = 1'b0;
        ring_push(CH_BSLASH);
        ring_push(nibble_char(4'(i >> 4)));
        ring_push(nibble_char(4'(i)));
        ring_push(CH_NL);
      end
    end
  endfunction

  function automatic packet_t run_poll(input logic ep_ready);
    packet_t p;
    int      span;
    int      k;
    p = '0;
    if (ep_ready && (wr_ptr != rd_ptr || armed)) begin
      // A packet never runs past the end of the ring.
      span = (wr_ptr >= rd_ptr) ? int'(wr_ptr) - int'(rd_ptr) : RING_DEPTH - int'(rd_ptr);
      if (span > PACKET_BYTES) begin
        span = PACKET_BYTES;
      end
      for (k = 0; k < span; k++) begin
        p.bytes[8*k +: 8] = ring_copy[RING_AW'(rd_ptr + RING_AW'(k))];
      end
      rd_ptr = RING_AW'(rd_ptr + RING_AW'(span));
      armed = (span == PACKET_BYTES) && (wr_ptr == rd_ptr);
      p.sent = 1'b1;
      p.len = LEN_W'(span);
    end
    report_lowest_flag();
    p.ovf = dropped;
    return p;
  endfunction

  always @(posedge clk) begin : watch
    packet_t got;
    packet_t want;
    if (rst) begin
      wr_ptr = '0;
      rd_ptr = '0;
      flags = '0;
      armed = 1'b0;
      dropped = 1'b0;
      scan_lo = SCAN_LOW_AT_RESET;
      scan_hi = SCAN_HIGH_AT_RESET;
      packets_due.delete();
    end else begin
      if (write_enable) begin
        if (reg_index == REG_SCAN_LOW) begin
          scan_lo = write_data;
        end else if (reg_index == REG_SCAN_HIGH) begin
          scan_hi = write_data;
        end
      end
      if (item_bus.valid && item_bus.ready) begin
        case (op_t'(item_bus.operation))
          OP_RAISE: flags = flags | item_bus.raise_mask;
          OP_PUT:   ring_push(item_bus.byte_value);
          OP_ARM:   armed = 1'b1;
          default:  packets_due.push_back(run_poll(item_bus.endpoint_ready));
        endcase
      end
      if (result_bus.valid && result_bus.ready) begin
        got = '{sent: result_bus.packet_valid, len: result_bus.packet_length,
                bytes: result_bus.packet_data, ovf: result_bus.overflow_seen};
        if (packets_due.size() == 0) begin
          $error("result word arrived with no poll outstanding");
          fail_total++;
        end else begin
          want = packets_due.pop_front();
          if (got.sent !== want.sent) begin
            $error("packet_valid: expected %0d, got %0d", want.sent, got.sent);
            fail_total++;
          end
          if (got.len !== want.len) begin
            $error("packet_length: expected %0d, got %0d", want.len, got.len);
            fail_total++;
          end
          if (got.bytes !== want.bytes) begin
            $error("packet_data: expected %h, got %h", want.bytes, got.bytes);
            fail_total++;
          end
          if (got.ovf !== want.ovf) begin
            $error("overflow_seen: expected %0d, got %0d", want.ovf, got.ovf);
            fail_total++;
          end
        end
      end
    end
    packets_due_count <= packets_due.size();
    mismatches <= fail_total;
  end

endmodule
`default_nettype wire

// ===== tb/interrupt_report_tx_packetizer_test.sv =====
// Top of the packetizer testbench: clock, reset, stimulus, result acceptance and verdict.
`default_nettype none
module interrupt_report_tx_packetizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import irtp_pkg::*;

  // Settling pause, long enough for the block to finish a poll from acceptance
  // to the output register and anything else in flight.
  localparam int SETTLE_CYCLES  = 24;
  // Length of the deliberate hold-off on the result side.
  localparam int LONG_HOLD      = 200;
  // Cycles without any accepted word before the run is declared hung. The
  // longest quiet stretch in a correct run is the long hold plus one gap,
  // one poll and the settling pause, well under this figure.
  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic              write_enable;
  logic [RIDX_W-1:0] reg_index;
  logic [CFG_W-1:0]  write_data;

  int packets_due_count;
  int mismatches;

  // Set for the closing phase, where neither side idles.
  logic calm = 1'b0;
  // The stimulus asks for a long result hold-off by bumping this count; the
  // result process serves each request once.
  int long_hold_asks = 0;

  irtp_in_if  item_bus ();
  irtp_out_if result_bus ();

  always #5ns clk = ~clk;

  interrupt_report_tx_packetizer dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item_bus),
    .result       (result_bus),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  irtp_packet_checker checker_inst (
    .clk               (clk),
    .rst               (rst),
    .item_bus          (item_bus),
    .result_bus        (result_bus),
    .write_enable      (write_enable),
    .reg_index         (reg_index),
    .write_data        (write_data),
    .packets_due_count (packets_due_count),
    .mismatches        (mismatches)
  );

  // Offers one input word and returns on the edge that accepts it. Now and
  // then the sender first goes quiet for a burst of cycles, except in the
  // closing phase.
  task automatic offer(input op_t op, input logic [MASK_W-1:0] mask,
                       input logic [7:0] value, input logic ep);
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    item_bus.valid          <= 1'b1;
    item_bus.operation      <= op;
    item_bus.raise_mask     <= mask;
    item_bus.byte_value     <= value;
    item_bus.endpoint_ready <= ep;
    @(posedge clk);
    while (item_bus.ready !== 1'b1) @(posedge clk);
  endtask

  // A random word. Puts and polls dominate so that the ring keeps cycling
  // and wraps; the fields an operation ignores are random as well. Raise
  // masks are dense, single-bit or sparse, so that both early and late flags
  // sit in the pending set.
  task automatic offer_random();
    int                pick;
    logic [MASK_W-1:0] mask;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       mask = $urandom;
      1:       mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      default: mask = $urandom & $urandom & $urandom;
    endcase
    if (pick < 25) begin
      offer(OP_RAISE, mask, 8'($urandom), 1'($urandom));
    end else if (pick < 60) begin
      offer(OP_PUT, mask, 8'($urandom), 1'($urandom));
    end else if (pick < 90) begin
      offer(OP_POLL, mask, 8'($urandom), $urandom_range(0, 9) != 0);
    end else begin
      offer(OP_ARM, mask, 8'($urandom), 1'($urandom));
    end
  endtask

  // Stops offering, waits until every poll has delivered its result word,
  // then lets the block run out any raise, put or arm still in progress.
  task automatic let_block_settle();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (packets_due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both scan range registers on consecutive edges; the block is idle.
  task automatic set_scan_range(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    write_enable <= 1'b1;
    reg_index    <= REG_SCAN_LOW;
    write_data   <= lo;
    @(posedge clk);
    reg_index    <= REG_SCAN_HIGH;
    write_data   <= hi;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] corner_bytes [8];
    corner_bytes = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'ha5, 8'h5a};

    item_bus.valid          <= 1'b0;
    item_bus.operation      <= OP_RAISE;
    item_bus.raise_mask     <= '0;
    item_bus.byte_value     <= '0;
    item_bus.endpoint_ready <= 1'b0;
    write_enable            <= 1'b0;
    reg_index               <= REG_SCAN_LOW;
    write_data              <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset scan range of 4 to 26.
    // A poll on an empty ring with nothing armed sends nothing.
    offer(OP_POLL, '0, '0, 1'b1);
    // An armed empty frame goes out with length zero.
    offer(OP_ARM, '0, '0, 1'b0);
    offer(OP_POLL, '0, '0, 1'b1);
    // Exactly one full packet empties the ring, which leaves the empty frame
    // armed, so the following poll sends a zero length frame.
    foreach (corner_bytes[i]) begin
      offer(OP_PUT, '0, corner_bytes[i], 1'b0);
    end
    offer(OP_POLL, '0, '0, 1'b1);
    offer(OP_POLL, '0, '0, 1'b1);
    // Raise every flag; an endpoint that is not ready still lets the scan
    // report the lowest flag in range.
    offer(OP_RAISE, '1, '0, 1'b0);
    offer(OP_POLL, '1, 8'hff, 1'b0);
    offer(OP_POLL, '0, '0, 1'b1);
    offer(OP_RAISE, '0, 8'hff, 1'b1);
    offer(OP_POLL, '0, '0, 1'b1);
    offer(OP_POLL, '0, '0, 1'b1);
    let_block_settle();

    // Full scan range, with one long hold-off on the result side while the
    // sender keeps offering, so that the block backs up into its input.
    set_scan_range(5'd0, 5'd31);
    long_hold_asks++;
    repeat (40) offer_random();
    let_block_settle();

    // Empty scan range: low above high, nothing is ever reported.
    set_scan_range(5'd31, 5'd0);
    repeat (20) offer_random();
    let_block_settle();

    // Overflow: with only the top flag in range, fill the ring past capacity
    // without polling, then let a report find the ring full as well, then
    // drain everything.
    set_scan_range(5'd31, 5'd31);
    offer(OP_RAISE, '1, '0, 1'b0);
    repeat (RING_DEPTH + 2) offer(OP_PUT, $urandom, 8'($urandom), 1'($urandom));
    offer(OP_POLL, '0, '0, 1'b0);
    repeat (40) offer(OP_POLL, $urandom, 8'($urandom), 1'b1);
    let_block_settle();

    // Single flag at the bottom of the range.
    set_scan_range(5'd0, 5'd0);
    repeat (15) offer_random();
    let_block_settle();

    set_scan_range(CFG_W'($urandom), CFG_W'($urandom));
    repeat (15) offer_random();
    let_block_settle();

    // Closing phase at full rate on both sides.
    calm = 1'b1;
    set_scan_range(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(16, 31)));
    repeat (25) offer_random();
    let_block_settle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side. Each pass sets ready once and holds it: a long hold-off
  // when one is requested, otherwise random stall bursts between random
  // runs of acceptance, and no stalls in the closing phase.
  initial begin : result_taker
    int served;
    served = 0;
    result_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (served != long_hold_asks) begin
        served++;
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        result_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Watchdog: any accepted word on either channel restarts the count.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/irtp_pkg.sv
sv/irtp_if.sv
sv/irtp_ram.sv
sv/interrupt_report_tx_packetizer.sv
tb/irtp_packet_checker.sv
tb/interrupt_report_tx_packetizer_test.sv
